[design/slpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpc_pkg: shared types and constants
// Item kinds, register indexes and the per-switch command/status structs.
// ----------------------------------------------------------------------------
package slpc_pkg;

	localparam int unsigned NUM_SW       = 3;
	localparam int unsigned COUNT_W      = 8;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned CFG_DATA_W   = 8;
	localparam int unsigned S_TDATA_W    = 8;
	localparam int unsigned M_TDATA_W    = 16;

	localparam logic [COUNT_W-1:0] LONG_TICKS_RST = 8'd63;
	localparam logic               RELEASE_RST    = 1'b1;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_EDGE = 2'd1,
		KIND_READ = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LONG_TICKS = 1'b0,
		CFG_RELEASE    = 1'b1
	} cfg_idx_t;

	// command to one switch channel, valid for one cycle
	typedef struct packed {
		logic tick;
		logic arm;
		logic clear;
		logic level;
	} sw_cmd_t;

	typedef struct packed {
		logic short_flag;
		logic long_flag;
	} sw_stat_t;

endpackage
`default_nettype wire

[design/slpc_switch.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpc_switch: press timer for one switch
// Holds the armed bit, the hold counter and the sticky short/long flags.
// ----------------------------------------------------------------------------
module slpc_switch (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire slpc_pkg::sw_cmd_t                cmd,
	input  wire logic [slpc_pkg::COUNT_W-1:0]     long_ticks,
	input  wire logic                             release_level,
	output slpc_pkg::sw_stat_t                    stat
);

	logic                           armed_q;
	logic [slpc_pkg::COUNT_W-1:0]   count_q;
	logic                           short_q;
	logic                           long_q;
	logic                           is_long;
	logic                           is_short;

	assign is_long  = (count_q >= long_ticks);
	assign is_short = (cmd.level == release_level);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			count_q <= '0;
			short_q <= 1'b0;
			long_q  <= 1'b0;
		end else begin
			if (cmd.tick && armed_q) begin
				priority if (is_long) begin
					long_q  <= 1'b1;
					armed_q <= 1'b0;
					count_q <= '0;
				end else if (is_short) begin
					short_q <= 1'b1;
					armed_q <= 1'b0;
					count_q <= '0;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			// re-arm keeps the running count
			if (cmd.arm)
				armed_q <= 1'b1;
			if (cmd.clear) begin
				short_q <= 1'b0;
				long_q  <= 1'b0;
			end
		end
	end

	assign stat.short_flag = short_q;
	assign stat.long_flag  = long_q;

endmodule
`default_nettype wire

[design/short_long_press_classifier_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// short_long_press_classifier_top: short/long press classifier, three switches
// Stream in tick, edge and read words; read words return the latched flags.
// ----------------------------------------------------------------------------
// Usage:
//  s_* channel: one word per item, s_tuser is the kind (tick, edge, read).
//   Edge words arm the switches in edge_mask; tick words advance the hold
//   timers of armed switches and latch short or long presses.
//  m_* channel: one word for each read item: latched short and long flags
//   plus the pin levels of the read word. Flags clear on read.
//  cfg_*: registers written when cfg_we is high (0 = long press ticks,
//   1 = release level). Write only while the block is idle.
// Timing: input register, then state update and output register. m_tvalid
//  rises after a read word passes the input and output registers (two
//  register stages). One word per cycle is sustained except while a read
//  word waits; the only limit is the single output register.
// Stall: while a result waits on m_tready, ticks and edges still pass; a
//  further read word waits in the input register and s_tready drops.
// Reset: all switches disarmed, counters and flags cleared, registers at
//  63 ticks and release level 1.
// ----------------------------------------------------------------------------
module short_long_press_classifier_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [slpc_pkg::S_TDATA_W-1:0] s_tdata, // edge_mask[2:0] pin_levels[5:3]
	input  wire logic [1:0]                          s_tuser,  // kind[1:0]
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [slpc_pkg::M_TDATA_W-1:0] m_tdata, // short_flags[2:0] long_flags[5:3] levels_now[8:6]
	input  wire logic                                cfg_we,
	input  wire logic [slpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [slpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned N = slpc_pkg::NUM_SW;

	logic [slpc_pkg::COUNT_W-1:0] long_ticks_q;
	logic                         release_q;

	logic                  valid_s1;
	slpc_pkg::kind_t       kind_s1;
	logic [N-1:0]          mask_s1;
	logic [N-1:0]          levels_s1;
	logic                  adv_s1;
	logic                  is_read_s1;

	logic                  m_valid_q;
	logic [N-1:0]          short_out_q;
	logic [N-1:0]          long_out_q;
	logic [N-1:0]          levels_out_q;

	slpc_pkg::sw_cmd_t     cmd    [N];
	slpc_pkg::sw_stat_t    stat   [N];
	logic [N-1:0]          short_w;
	logic [N-1:0]          long_w;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q <= slpc_pkg::LONG_TICKS_RST;
			release_q    <= slpc_pkg::RELEASE_RST;
		end else if (cfg_we) begin
			unique case (slpc_pkg::cfg_idx_t'(cfg_index))
				slpc_pkg::CFG_LONG_TICKS: long_ticks_q <= cfg_data;
				slpc_pkg::CFG_RELEASE:    release_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	assign is_read_s1 = (kind_s1 == slpc_pkg::KIND_READ);
	assign adv_s1     = valid_s1 && (!is_read_s1 || !m_valid_q || m_tready);
	assign s_tready   = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1   <= slpc_pkg::kind_t'(s_tuser);
			mask_s1   <= s_tdata[N-1:0];
			levels_s1 <= s_tdata[2*N-1:N];
		end
	end

	// per-switch timers
	for (genvar i = 0; i < N; i++) begin : g_sw
		assign cmd[i].tick  = adv_s1 && (kind_s1 == slpc_pkg::KIND_TICK);
		assign cmd[i].arm   = adv_s1 && (kind_s1 == slpc_pkg::KIND_EDGE) && mask_s1[i];
		assign cmd[i].clear = adv_s1 && is_read_s1;
		assign cmd[i].level = levels_s1[i];

		slpc_switch u_sw (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd[i]),
			.long_ticks   (long_ticks_q),
			.release_level(release_q),
			.stat         (stat[i])
		);

		assign short_w[i] = stat[i].short_flag;
		assign long_w[i]  = stat[i].long_flag;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (adv_s1 && is_read_s1)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_read_s1) begin
			short_out_q  <= short_w;
			long_out_q   <= long_w;
			levels_out_q <= levels_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(slpc_pkg::M_TDATA_W - 3*N){1'b0}},
	                   levels_out_q, long_out_q, short_out_q};

	// checks
	a_read_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && is_read_s1 |=> m_tvalid)
		else $error("read word did not produce a result");

	a_flags_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && is_read_s1 |=> (short_w == '0) && (long_w == '0))
		else $error("flags not cleared after read");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && is_read_s1 && valid_s1 |-> !adv_s1)
		else $error("pending result overwritten");

endmodule
`default_nettype wire
